// File: hw/rtl/sidt_pkg.sv
// sidt_pkg: shared types, status codes and controller states for the id/context table.
// No dependencies.
`timescale 1ns / 1ps
package sidt_pkg;
	localparam int unsigned CapacityDef = 256;
	localparam int unsigned BucketsDef = 128;
	localparam int unsigned ContextWDef = 64;
	localparam int unsigned SidW = 32;
	localparam int unsigned CtxPortW = 64;
	localparam int unsigned StatusW = 3;

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_REMOVE = 2'd1,
		FN_SEARCH = 2'd2,
		FN_CTX2ID = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_EXISTS = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL = 3'd3,
		ST_ALLOC_FAIL = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_WRITE,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture request, clear scan results
		logic scan_clr;  // restart scan index
		logic scan_step; // evaluate current slot, advance
		logic write_new; // store pending insert
		logic clear_hit; // free id match slot
		logic out_load;  // capture result
	} sidt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
		logic id_hit;
		logic ctx_hit;
		logic free_ok;
		logic nid_zero;
		func_t func;
	} sidt_sts_t;
endpackage

// File: hw/rtl/sidt_if.sv
// sidt_if: valid/ready channel carrying the request or response payload.
// Depends on sidt_pkg.
`timescale 1ns / 1ps
interface sidt_req_if;
	import sidt_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] func;
	logic [SidW-1:0] sid;
	logic [CtxPortW-1:0] context_req;
	modport source (output valid, func, sid, context_req, input ready);
	modport sink (input valid, func, sid, context_req, output ready);
endinterface

interface sidt_rsp_if;
	import sidt_pkg::*;
	logic valid;
	logic ready;
	logic [StatusW-1:0] status;
	logic [SidW-1:0] found_sid;
	logic [CtxPortW-1:0] context_out;
	modport source (output valid, status, found_sid, context_out, input ready);
	modport sink (input valid, status, found_sid, context_out, output ready);
endinterface

// File: hw/rtl/sidt_ctrl.sv
// sidt_ctrl: controller state machine sequencing scan, decision, write-back and output.
// Depends on sidt_pkg.
`timescale 1ns / 1ps
module sidt_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sidt_pkg::sidt_sts_t sts,
	output sidt_pkg::sidt_cmd_t cmd
);
	import sidt_pkg::*;
	state_t state_q, state_d;
	logic out_valid_q;
	logic out_take;

	assign out_take = out_valid_q && out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_take) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				state_d = S_WRITE;
			end
			S_WRITE: begin
				if (!out_valid_q || out_take) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
					unique case (sts.func)
						FN_INSERT: cmd.write_new = !sts.id_hit && sts.free_ok;
						FN_REMOVE: cmd.clear_hit = sts.id_hit;
						FN_SEARCH: ;
						FN_CTX2ID: cmd.write_new = !sts.ctx_hit && !sts.nid_zero
							&& !sts.id_hit && sts.free_ok;
						default: ;
					endcase
				end
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// File: hw/rtl/sidt_dp.sv
// sidt_dp: entry memories, valid bits, insert counter, one-slot-per-cycle scan and result.
// Depends on sidt_pkg.
`timescale 1ns / 1ps
module sidt_dp #(
	parameter int unsigned CAPACITY = sidt_pkg::CapacityDef,
	parameter int unsigned BUCKETS = sidt_pkg::BucketsDef,
	parameter int unsigned CONTEXT_W = sidt_pkg::ContextWDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [1:0] req_func,
	input  logic [sidt_pkg::SidW-1:0] req_sid,
	input  logic [sidt_pkg::CtxPortW-1:0] req_context,
	input  sidt_pkg::sidt_cmd_t cmd,
	output sidt_pkg::sidt_sts_t sts,
	output logic [sidt_pkg::StatusW-1:0] status,
	output logic [sidt_pkg::SidW-1:0] found_sid,
	output logic [sidt_pkg::CtxPortW-1:0] context_out
);
	import sidt_pkg::*;
	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int unsigned RcpSh = (BUCKETS > 1) ? $clog2(BUCKETS) : 0;
	localparam logic [32:0] RcpM = 33'(((64'd1 << (32 + RcpSh)) + 64'(BUCKETS) - 64'd1)
		/ 64'(BUCKETS));

	logic [SidW-1:0] id_mem [CAPACITY];
	logic [CONTEXT_W-1:0] ctx_mem [CAPACITY];
	logic [SidW-1:0] stamp_mem [CAPACITY];
	logic [BW-1:0] bkt_mem [CAPACITY];
	logic [CAPACITY-1:0] valid_q;
	logic [SidW-1:0] count_q;

	func_t func_q;
	logic [SidW-1:0] sid_q;
	logic [CONTEXT_W-1:0] ctx_q;
	logic [SidW-1:0] key_q;
	logic [SidW-1:0] key_quo_q;
	logic [BW-1:0] key_b_q;

	logic [AW-1:0] idx_q;
	logic [AW-1:0] rd_a;
	logic rd_v_s1;
	logic [AW-1:0] rd_a_s1;
	logic [SidW-1:0] rd_id_s1, rd_stamp_s1;
	logic [CONTEXT_W-1:0] rd_ctx_s1;
	logic [BW-1:0] rd_b_s1;
	logic scan_run_q;

	logic id_hit_q, ctx_hit_q, free_ok_q;
	logic [AW-1:0] id_slot_q, free_slot_q;
	logic [CONTEXT_W-1:0] hit_ctx_q;
	logic [SidW-1:0] best_id_q, best_stamp_q;
	logic [BW-1:0] best_b_q;
	logic [BW-1:0] cur_b;
	logic better;

	logic [StatusW-1:0] status_d;
	logic [SidW-1:0] fsid_d;
	logic [CtxPortW-1:0] cout_d;

	assign rd_a = idx_q;
	assign cur_b = rd_b_s1;
	assign better = !ctx_hit_q || (cur_b < best_b_q)
		|| (cur_b == best_b_q && rd_stamp_s1 > best_stamp_q);

	always_comb begin
		status_d = ST_OK;
		fsid_d = '0;
		cout_d = '0;
		unique case (func_q)
			FN_INSERT: status_d = id_hit_q ? ST_EXISTS : (free_ok_q ? ST_OK : ST_FULL);
			FN_REMOVE: status_d = id_hit_q ? ST_OK : ST_NOT_FOUND;
			FN_SEARCH: begin
				status_d = id_hit_q ? ST_OK : ST_NOT_FOUND;
				if (id_hit_q) cout_d = CtxPortW'(hit_ctx_q);
			end
			FN_CTX2ID: begin
				if (ctx_hit_q) fsid_d = best_id_q;
				else if (key_q == '0 || id_hit_q || !free_ok_q) status_d = ST_ALLOC_FAIL;
				else fsid_d = key_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func_t'(req_func);
			sid_q <= req_sid;
			ctx_q <= req_context[CONTEXT_W-1:0];
			key_q <= (func_t'(req_func) == FN_CTX2ID) ? count_q + 1'b1 : req_sid;
		end
		key_quo_q <= SidW'((65'(key_q) * 65'(RcpM)) >> (32 + RcpSh));
		key_b_q <= BW'(key_q - SidW'(key_quo_q * BUCKETS));
		rd_id_s1 <= id_mem[rd_a];
		rd_ctx_s1 <= ctx_mem[rd_a];
		rd_stamp_s1 <= stamp_mem[rd_a];
		rd_b_s1 <= bkt_mem[rd_a];
		rd_a_s1 <= rd_a;
		if (cmd.write_new) begin
			id_mem[free_slot_q] <= key_q;
			ctx_mem[free_slot_q] <= ctx_q;
			stamp_mem[free_slot_q] <= count_q;
			bkt_mem[free_slot_q] <= key_b_q;
		end
		if (cmd.out_load) begin
			status <= status_d;
			found_sid <= fsid_d;
			context_out <= cout_d;
		end
		if (cmd.load) begin
			id_hit_q <= 1'b0;
			ctx_hit_q <= 1'b0;
			free_ok_q <= 1'b0;
		end else if (rd_v_s1) begin
			if (valid_q[rd_a_s1]) begin
				if (rd_id_s1 == key_q && !id_hit_q) begin
					id_hit_q <= 1'b1;
					id_slot_q <= rd_a_s1;
					hit_ctx_q <= rd_ctx_s1;
				end
				if (rd_ctx_s1 == ctx_q && better) begin
					ctx_hit_q <= 1'b1;
					best_b_q <= cur_b;
					best_stamp_q <= rd_stamp_s1;
					best_id_q <= rd_id_s1;
				end
			end else if (!free_ok_q) begin
				free_ok_q <= 1'b1;
				free_slot_q <= rd_a_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			idx_q <= '0;
			rd_v_s1 <= 1'b0;
			scan_run_q <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.scan_step && scan_run_q;
			if (cmd.scan_clr) begin
				idx_q <= '0;
				scan_run_q <= 1'b1;
			end else if (cmd.scan_step && scan_run_q) begin
				if (idx_q == AW'(CAPACITY - 1)) scan_run_q <= 1'b0;
				else idx_q <= idx_q + 1'b1;
			end
			if (cmd.write_new) begin
				valid_q[free_slot_q] <= 1'b1;
				count_q <= count_q + 1'b1;
			end
			if (cmd.clear_hit) valid_q[id_slot_q] <= 1'b0;
		end
	end

	always_comb begin
		sts.scan_last = !scan_run_q && !rd_v_s1;
		sts.id_hit = id_hit_q;
		sts.ctx_hit = ctx_hit_q;
		sts.free_ok = free_ok_q;
		sts.nid_zero = (key_q == '0);
		sts.func = func_q;
	end
endmodule

// File: hw/rtl/security_id_context_table_unit.sv
// security_id_context_table_unit: top level joining controller and datapath.
// Depends on sidt_pkg, sidt_if, sidt_ctrl, sidt_dp.
// One request at a time: the one-slot-per-cycle scan, a decide step and write-back
// load the response; the next request transfer can follow in the cycle after that load;
// a stalled response holds the unit in write-back.
// Reset clears all valid bits and the insert count at once; no clearing pass.
`timescale 1ns / 1ps
module security_id_context_table_unit #(
	parameter int unsigned CAPACITY = sidt_pkg::CapacityDef,
	parameter int unsigned BUCKETS = sidt_pkg::BucketsDef,
	parameter int unsigned CONTEXT_W = sidt_pkg::ContextWDef
) (
	input logic clk,
	input logic arst_n,
	sidt_req_if.sink req,
	sidt_rsp_if.source rsp
);
	import sidt_pkg::*;
	sidt_cmd_t cmd;
	sidt_sts_t sts;

	sidt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.sts(sts), .cmd(cmd)
	);

	sidt_dp #(.CAPACITY(CAPACITY), .BUCKETS(BUCKETS), .CONTEXT_W(CONTEXT_W)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.req_func(req.func), .req_sid(req.sid), .req_context(req.context_req),
		.cmd(cmd), .sts(sts),
		.status(rsp.status), .found_sid(rsp.found_sid), .context_out(rsp.context_out)
	);
endmodule

// File: bench/tb_top.sv
// tb_top: self-checking bench for security_id_context_table_unit (id/context map).
// Drives requests over sidt_req_if, checks each response against an in-bench table model
// or, for directed rows, a given expected reply. Depends on sidt_pkg, sidt_if and the RTL of the unit.
`timescale 1ns / 1ps
module tb_top;
	import sidt_pkg::*;

	localparam int unsigned SLOTS = CapacityDef;
	localparam int unsigned NBUCKET = BucketsDef;

	typedef struct {
		status_t status;
		logic [SidW-1:0] sid;
		logic [CtxPortW-1:0] ctx;
	} reply_t;

	typedef struct {
		func_t func;
		logic [SidW-1:0] sid;
		logic [CtxPortW-1:0] ctx;
		bit typed;
		reply_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	sidt_req_if req ();
	sidt_rsp_if rsp ();

	security_id_context_table_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	// table model
	bit model_valid [SLOTS];
	logic [SidW-1:0] model_id [SLOTS];
	logic [CtxPortW-1:0] model_ctx [SLOTS];
	logic [31:0] model_stamp [SLOTS];
	logic [31:0] model_count;

	reply_t pending_replies[$];
	dir_row_t dir_rows[$];
	logic [SidW-1:0] known_ids[$];
	int idle_pct;
	int stall_pct;
	int errors;
	int checked;
	int func_seen [4];
	int status_seen [5];

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int find_slot(logic [SidW-1:0] id);
		for (int i = 0; i < SLOTS; i++)
			if (model_valid[i] && model_id[i] == id)
				return i;
		return -1;
	endfunction

	function automatic int occupancy();
		int n;
		n = 0;
		for (int i = 0; i < SLOTS; i++)
			n += model_valid[i];
		return n;
	endfunction

	function automatic status_t store_pair(logic [SidW-1:0] id, logic [CtxPortW-1:0] ctx);
		if (find_slot(id) >= 0)
			return ST_EXISTS;
		for (int i = 0; i < SLOTS; i++) begin
			if (!model_valid[i]) begin
				model_valid[i] = 1'b1;
				model_id[i] = id;
				model_ctx[i] = ctx;
				model_stamp[i] = model_count;
				model_count = model_count + 32'd1;
				return ST_OK;
			end
		end
		return ST_FULL;
	endfunction

	function automatic reply_t table_lookup(func_t func, logic [SidW-1:0] id,
			logic [CtxPortW-1:0] ctx);
		reply_t r;
		int slot;
		int best;
		logic [6:0] bb;
		logic [31:0] bs;
		logic [31:0] nid;
		r.status = ST_OK;
		r.sid = '0;
		r.ctx = '0;
		case (func)
			FN_INSERT: begin
				r.status = store_pair(id, ctx);
			end
			FN_REMOVE: begin
				slot = find_slot(id);
				if (slot < 0)
					r.status = ST_NOT_FOUND;
				else
					model_valid[slot] = 1'b0;
			end
			FN_SEARCH: begin
				slot = find_slot(id);
				if (slot < 0)
					r.status = ST_NOT_FOUND;
				else
					r.ctx = model_ctx[slot];
			end
			default: begin
				best = -1;
				bb = '0;
				bs = '0;
				for (int i = 0; i < SLOTS; i++) begin
					if (model_valid[i] && model_ctx[i] == ctx) begin
						if (best < 0 || model_id[i] % NBUCKET < bb ||
								(model_id[i] % NBUCKET == bb && model_stamp[i] > bs)) begin
							best = i;
							bb = model_id[i] % NBUCKET;
							bs = model_stamp[i];
						end
					end
				end
				if (best >= 0) begin
					r.sid = model_id[best];
				end else begin
					nid = model_count + 32'd1;
					if (nid == 32'd0 || store_pair(nid, ctx) != ST_OK)
						r.status = ST_ALLOC_FAIL;
					else
						r.sid = nid;
				end
			end
		endcase
		return r;
	endfunction

	// hold valid across back-to-back transfers; drop it only when idling
	task automatic send(func_t func, logic [SidW-1:0] id, logic [CtxPortW-1:0] ctx,
			bit typed, reply_t want);
		reply_t r;
		if ($urandom_range(99) < idle_pct) begin
			req.valid <= 1'b0;
			req.func <= 2'($urandom);
			req.sid <= $urandom;
			req.context_req <= {$urandom, $urandom};
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		req.valid <= 1'b1;
		req.func <= func;
		req.sid <= id;
		req.context_req <= ctx;
		do @(posedge clk); while (!req.ready);
		r = table_lookup(func, id, ctx);
		pending_replies.push_back(typed ? want : r);
		func_seen[func]++;
		if (func == FN_INSERT && r.status == ST_OK)
			known_ids.push_back(id);
		if (func == FN_CTX2ID && r.status == ST_OK)
			known_ids.push_back(r.sid);
	endtask

	task automatic send_random();
		int pick;
		logic [SidW-1:0] id;
		logic [CtxPortW-1:0] ctx;
		reply_t none;
		none = '{ST_OK, '0, '0};
		pick = $urandom_range(99);
		if (pick < 40 && known_ids.size() > 0)
			id = known_ids[$urandom_range(known_ids.size() - 1)];
		else if (pick < 75)
			id = $urandom_range(300);
		else
			id = $urandom;
		pick = $urandom_range(99);
		if (pick < 55)
			ctx = 64'($urandom_range(7));
		else if (pick < 65)
			ctx = {64{1'b1}};
		else
			ctx = {$urandom, $urandom};
		send(func_t'($urandom_range(3)), id, ctx, 1'b0, none);
	endtask

	function automatic void add_row(func_t func, logic [SidW-1:0] id,
			logic [CtxPortW-1:0] ctx, bit typed, status_t st,
			logic [SidW-1:0] wsid, logic [CtxPortW-1:0] wctx);
		dir_row_t row;
		row.func = func;
		row.sid = id;
		row.ctx = ctx;
		row.typed = typed;
		row.want = '{st, wsid, wctx};
		dir_rows.push_back(row);
	endfunction

	always @(posedge clk) begin
		reply_t want;
		if (rsp.valid && rsp.ready) begin
			if (pending_replies.size() == 0) begin
				errors++;
				$display("%0t: unexpected transfer status=%0d sid=%h ctx=%h", $time,
					rsp.status, rsp.found_sid, rsp.context_out);
			end else begin
				want = pending_replies.pop_front();
				checked++;
				status_seen[want.status]++;
				if (rsp.status !== want.status) begin
					errors++;
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, rsp.status);
				end
				if (rsp.found_sid !== want.sid) begin
					errors++;
					$display("%0t: found_sid expected %h actual %h", $time,
						want.sid, rsp.found_sid);
				end
				if (rsp.context_out !== want.ctx) begin
					errors++;
					$display("%0t: context_out expected %h actual %h", $time,
						want.ctx, rsp.context_out);
				end
			end
		end
		if (arst_n)
			rsp.ready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		reply_t none;
		int k;
		none = '{ST_OK, '0, '0};
		errors = 0;
		checked = 0;
		idle_pct = 0;
		stall_pct = 0;
		model_count = '0;
		for (int i = 0; i < SLOTS; i++)
			model_valid[i] = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.func = FN_INSERT;
		req.sid = '0;
		req.context_req = '0;
		rsp.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(FN_SEARCH, 32'd0, 64'd0, 1, ST_NOT_FOUND, 0, 0);
		add_row(FN_REMOVE, 32'hFFFF_FFFF, '1, 1, ST_NOT_FOUND, 0, 0);
		add_row(FN_CTX2ID, 32'd0, 64'hDEAD, 1, ST_OK, 32'd1, 0);
		add_row(FN_INSERT, 32'd0, 64'd0, 1, ST_OK, 0, 0);
		add_row(FN_INSERT, 32'hFFFF_FFFF, '1, 1, ST_OK, 0, 0);
		add_row(FN_INSERT, 32'd0, 64'd5, 1, ST_EXISTS, 0, 0);
		add_row(FN_SEARCH, 32'hFFFF_FFFF, 64'd0, 1, ST_OK, 0, '1);
		add_row(FN_SEARCH, 32'd0, '1, 1, ST_OK, 0, 64'd0);
		add_row(FN_CTX2ID, 32'd7, '1, 1, ST_OK, 32'hFFFF_FFFF, 0);
		add_row(FN_CTX2ID, 32'd0, 64'hDEAD, 1, ST_OK, 32'd1, 0);
		add_row(FN_CTX2ID, 32'd0, 64'h77, 1, ST_OK, 32'd4, 0);
		add_row(FN_INSERT, 32'd6, 64'h99, 1, ST_OK, 0, 0);
		add_row(FN_CTX2ID, 32'd0, 64'h55, 1, ST_ALLOC_FAIL, 0, 0);
		add_row(FN_REMOVE, 32'd1, 64'd0, 1, ST_OK, 0, 0);
		add_row(FN_SEARCH, 32'd1, 64'd0, 1, ST_NOT_FOUND, 0, 0);
		add_row(FN_INSERT, 32'd130, 64'hAA, 0, ST_OK, 0, 0);
		add_row(FN_INSERT, 32'd257, 64'hAA, 0, ST_OK, 0, 0);
		add_row(FN_INSERT, 32'd129, 64'hAA, 0, ST_OK, 0, 0);
		add_row(FN_CTX2ID, 32'd0, 64'hAA, 0, ST_OK, 0, 0);
		add_row(FN_REMOVE, 32'd129, 64'd0, 0, ST_OK, 0, 0);
		add_row(FN_CTX2ID, 32'd0, 64'hAA, 0, ST_OK, 0, 0);
		add_row(FN_INSERT, 32'd129, 64'hAA, 0, ST_OK, 0, 0);
		add_row(FN_CTX2ID, 32'h5A5A_5A5A, 64'hAA, 0, ST_OK, 0, 0);
		add_row(FN_CTX2ID, 32'd0, 64'hF0F0_0F0F_A5A5_5A5A, 0, ST_OK, 0, 0);
		foreach (dir_rows[i])
			send(dir_rows[i].func, dir_rows[i].sid, dir_rows[i].ctx, dir_rows[i].typed,
				dir_rows[i].want);

		repeat (30) send_random();

		// fill the table to capacity, then probe the full cases
		idle_pct = 61;
		k = 0;
		while (occupancy() < SLOTS) begin
			send(FN_INSERT, 32'h1000_0000 + k, {$urandom, $urandom}, 1'b0, none);
			k++;
		end
		send(FN_INSERT, 32'h2000_0000, 64'd1, 1'b1, '{ST_FULL, '0, '0});
		send(FN_CTX2ID, 32'd0, 64'hFEED_0000_0000_0001, 1'b1, '{ST_ALLOC_FAIL, '0, '0});
		send(FN_INSERT, 32'h1000_0000, 64'd1, 1'b1, '{ST_EXISTS, '0, '0});

		repeat (35) send_random();
		idle_pct = 0;
		stall_pct = 61;
		repeat (35) send_random();
		idle_pct = 36;
		stall_pct = 36;
		repeat (35) send_random();

		@(posedge clk);
		req.valid <= 1'b0;
		k = 0;
		while (pending_replies.size() != 0 && k < 100_000) begin
			@(posedge clk);
			k++;
		end
		repeat (300) @(posedge clk);

		$display("Checked %0d responses: insert %0d, remove %0d, search %0d, ctx2id %0d.",
			checked, func_seen[0], func_seen[1], func_seen[2], func_seen[3]);
		$display("Statuses ok %0d, exists %0d, not_found %0d, full %0d, alloc_fail %0d.",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
		if (errors == 0 && pending_replies.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

// File: sim.f
hw/rtl/sidt_pkg.sv
hw/rtl/sidt_if.sv
hw/rtl/sidt_ctrl.sv
hw/rtl/sidt_dp.sv
hw/rtl/security_id_context_table_unit.sv
bench/tb_top.sv
